### design/mct_pkg.sv
`default_nettype none
package mct_pkg;

	localparam int GRID_DIM_DEF  = 256;
	localparam int FRAC_BITS_DEF = 8;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [15:0] ISO_RESET = 16'h8000;

	// register index codes (paddr[2] selects the 32-bit word)
	localparam logic REG_ISO_LEVEL = 1'b0;

	// one digit that ends a triangle table row
	localparam logic [3:0] ROW_END = 4'hf;

	// corner offsets along each axis, bit m for corner m
	localparam logic [7:0] CORNER_DX = 8'b0110_0110;
	localparam logic [7:0] CORNER_DY = 8'b1111_0000;
	localparam logic [7:0] CORNER_DZ = 8'b1100_1100;

	// one classified cube, as queued between front and back
	typedef struct packed {
		logic [7:0][15:0] corner;
		logic [7:0]       x;
		logic [7:0]       y;
		logic [7:0]       z;
		logic [59:0]      row;
		logic [2:0]       ntri;
	} cube_rec_t;

	// standard triangle table: edge digits first, padded with f
	localparam logic [63:0] TRI_ROWS [256] = '{
		64'hffffffffffffffff, 64'h083fffffffffffff, 64'h019fffffffffffff, 64'h183981ffffffffff,
		64'h12afffffffffffff, 64'h08312affffffffff, 64'h92a029ffffffffff, 64'h2832a8a98fffffff,
		64'h3b2fffffffffffff, 64'h0b28b0ffffffffff, 64'h19023bffffffffff, 64'h1b219b98bfffffff,
		64'h3a1ba3ffffffffff, 64'h0a108a8bafffffff, 64'h3903b9ba9fffffff, 64'h98aa8bffffffffff,
		64'h478fffffffffffff, 64'h430734ffffffffff, 64'h019847ffffffffff, 64'h419471731fffffff,
		64'h12a847ffffffffff, 64'h34730412afffffff, 64'h92a902847fffffff, 64'h2a9297273794ffff,
		64'h8473b2ffffffffff, 64'hb47b24204fffffff, 64'h90184723bfffffff, 64'h47b94b9b2921ffff,
		64'h3a13ba784fffffff, 64'h1ba14b1047b4ffff, 64'h47890b9bab03ffff, 64'h47b4b99bafffffff,
		64'h954fffffffffffff, 64'h954083ffffffffff, 64'h054150ffffffffff, 64'h854835315fffffff,
		64'h12a954ffffffffff, 64'h30812a495fffffff, 64'h52a542402fffffff, 64'h2a5325354348ffff,
		64'h95423bffffffffff, 64'h0b208b495fffffff, 64'h05401523bfffffff, 64'h21525828b485ffff,
		64'ha3ba13954fffffff, 64'h4950818a18baffff, 64'h54050b5bab03ffff, 64'h54858aa8bfffffff,
		64'h978579ffffffffff, 64'h930953573fffffff, 64'h078017157fffffff, 64'h153357ffffffffff,
		64'h978957a12fffffff, 64'ha12950530573ffff, 64'h802825857a52ffff, 64'h2a5253357fffffff,
		64'h7957893b2fffffff, 64'h95797292027bffff, 64'h23b018178157ffff, 64'hb21b17715fffffff,
		64'h958857a13a3bffff, 64'h5705097b010aba0f, 64'hba0b03a50807570f, 64'hba57b5ffffffffff,
		64'ha65fffffffffffff, 64'h0835a6ffffffffff, 64'h9015a6ffffffffff, 64'h1831985a6fffffff,
		64'h165261ffffffffff, 64'h165126308fffffff, 64'h965906026fffffff, 64'h598582526328ffff,
		64'h23ba65ffffffffff, 64'hb08b20a65fffffff, 64'h01923b5a6fffffff, 64'h5a61929b298bffff,
		64'h63b653513fffffff, 64'h08b0b50515b6ffff, 64'h3b6036065059ffff, 64'h65969bb98fffffff,
		64'h5a6478ffffffffff, 64'h43047365afffffff, 64'h1905a6847fffffff, 64'ha65197173794ffff,
		64'h612651478fffffff, 64'h125526304347ffff, 64'h847905065026ffff, 64'h739794329596269f,
		64'h3b2784a65fffffff, 64'h5a647242027bffff, 64'h01947823b5a6ffff, 64'h9219b294b7b45a6f,
		64'h8473b53515b6ffff, 64'h51b5b610b7b404bf, 64'h059065036b63847f, 64'h65969b4797b9ffff,
		64'ha4964affffffffff, 64'h4a649a083fffffff, 64'ha01a60640fffffff, 64'h83181686461affff,
		64'h149124264fffffff, 64'h308129249264ffff, 64'h024426ffffffffff, 64'h832824426fffffff,
		64'ha49a64b23fffffff, 64'h08228b49a4a6ffff, 64'h3b201606461affff, 64'h64161a48121b8b1f,
		64'h964936913b63ffff, 64'h8b1810b61914641f, 64'h3b6360064fffffff, 64'h648b68ffffffffff,
		64'h7a678a89afffffff, 64'h0730a709a67affff, 64'ha671a7178180ffff, 64'ha67a71173fffffff,
		64'h126168189867ffff, 64'h269291679093739f, 64'h780706602fffffff, 64'h732672ffffffffff,
		64'h23ba68a89867ffff, 64'h20727b09767a9a7f, 64'h1801781a767a23bf, 64'hb21b17a61671ffff,
		64'h896867916b63136f, 64'h091b67ffffffffff, 64'h7807063b0b60ffff, 64'h7b6fffffffffffff,
		64'h76bfffffffffffff, 64'h308b76ffffffffff, 64'h019b76ffffffffff, 64'h819831b76fffffff,
		64'ha126b7ffffffffff, 64'h12a3086b7fffffff, 64'h2902a96b7fffffff, 64'h6b72a3a83a98ffff,
		64'h723627ffffffffff, 64'h708760620fffffff, 64'h276237019fffffff, 64'h162186198876ffff,
		64'ha76a17137fffffff, 64'ha7617a187108ffff, 64'h03707a0a96a7ffff, 64'h76a7a88a9fffffff,
		64'h684b86ffffffffff, 64'h36b306046fffffff, 64'h86b846901fffffff, 64'h946963931b36ffff,
		64'h6846b82a1fffffff, 64'h12a30b06b046ffff, 64'h4b846b0292a9ffff, 64'ha93a32943b36463f,
		64'h823842462fffffff, 64'h042462ffffffffff, 64'h190234246438ffff, 64'h194142246fffffff,
		64'h8138618466a1ffff, 64'ha10a06604fffffff, 64'h4634386a3039a93f, 64'ha946a4ffffffffff,
		64'h49576bffffffffff, 64'h083495b76fffffff, 64'h50154076bfffffff, 64'hb76834354315ffff,
		64'h954a1276bfffffff, 64'h6b712a083495ffff, 64'h76b54a42a402ffff, 64'h348354325a52b76f,
		64'h723762549fffffff, 64'h954086062687ffff, 64'h362376150540ffff, 64'h628687218485158f,
		64'h954a16176137ffff, 64'h16a176107870954f, 64'h40a4a503a6a737af, 64'h76a7a854a48affff,
		64'h6956b9b89fffffff, 64'h36b063056095ffff, 64'h0b805b01556bffff, 64'h6b3635531fffffff,
		64'h12a95b9b8b56ffff, 64'h0b306b09656912af, 64'hb85b56805a52025f, 64'h6b36352a3a53ffff,
		64'h589528562382ffff, 64'h956960062fffffff, 64'h158180568382628f, 64'h156216ffffffffff,
		64'h13616a386569896f, 64'ha10a06950560ffff, 64'h03856affffffffff, 64'ha56fffffffffffff,
		64'hb5a75bffffffffff, 64'hb5ab75830fffffff, 64'h5b75ab190fffffff, 64'ha75ab7981831ffff,
		64'hb12b71751fffffff, 64'h08312717572bffff, 64'h9759279022b7ffff, 64'h75272b592328982f,
		64'h25a235375fffffff, 64'h820852875a25ffff, 64'h9015a35373a2ffff, 64'h982921872a25752f,
		64'h135375ffffffffff, 64'h087071175fffffff, 64'h903935537fffffff, 64'h987597ffffffffff,
		64'h5845a8ab8fffffff, 64'h5045b05abb30ffff, 64'h01984a8aba45ffff, 64'hab4a45b34941314f,
		64'h2512852b8458ffff, 64'h04b0b345b2b151bf, 64'h0250592b5458b85f, 64'h9452b3ffffffffff,
		64'h25a352345384ffff, 64'h5a2524420fffffff, 64'h3a235a385458019f, 64'h5a2524192942ffff,
		64'h845853351fffffff, 64'h045105ffffffffff, 64'h845853905035ffff, 64'h945fffffffffffff,
		64'h4b749b9abfffffff, 64'h0834979b79abffff, 64'h1ab1b414074bffff, 64'h3143481a474bab4f,
		64'h4b79b492b912ffff, 64'h9749b791b2b1083f, 64'hb74b42240fffffff, 64'hb74b42834324ffff,
		64'h29a279237749ffff, 64'h9a7974a27870207f, 64'h37a3a274a1a040af, 64'h1a2874ffffffffff,
		64'h491417713fffffff, 64'h491417081871ffff, 64'h403743ffffffffff, 64'h487fffffffffffff,
		64'h9a8ab8ffffffffff, 64'h30939bb9afffffff, 64'h01a0a88abfffffff, 64'h31ab3affffffffff,
		64'h12b1b99b8fffffff, 64'h30939b1292b9ffff, 64'h02b80bffffffffff, 64'h32bfffffffffffff,
		64'h23828aa89fffffff, 64'h9a2092ffffffffff, 64'h23828a0181a8ffff, 64'h1a2fffffffffffff,
		64'h138918ffffffffff, 64'h091fffffffffffff, 64'h038fffffffffffff, 64'hffffffffffffffff
	};

	// number of whole triangles in a row
	function automatic logic [2:0] tri_count(input logic [59:0] row);
		logic [2:0] n;
		n = 3'd0;
		for (int t = 0; t < 5; t++) begin
			if (row[59 - 12*t -: 4] != ROW_END) begin
				n = n + 3'd1;
			end
		end
		return n;
	endfunction

	// edge start corner
	function automatic logic [2:0] edge_from(input logic [3:0] e);
		return (e < 4'd8) ? e[2:0] : {1'b0, e[1:0]};
	endfunction

	// edge end corner
	function automatic logic [2:0] edge_to(input logic [3:0] e);
		logic [2:0] c;
		unique case (e[3:2])
			2'd0:    c = {1'b0, 2'(e[1:0] + 2'd1)};
			2'd1:    c = {1'b1, 2'(e[1:0] + 2'd1)};
			default: c = {1'b1, e[1:0]};
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

### design/mct_if.sv
`default_nettype none
interface mct_cube_if;
	logic        valid;
	logic        ready;
	logic [15:0] corner_0;
	logic [15:0] corner_1;
	logic [15:0] corner_2;
	logic [15:0] corner_3;
	logic [15:0] corner_4;
	logic [15:0] corner_5;
	logic [15:0] corner_6;
	logic [15:0] corner_7;
	logic [7:0]  cube_x;
	logic [7:0]  cube_y;
	logic [7:0]  cube_z;

	modport source (output valid, corner_0, corner_1, corner_2, corner_3, corner_4,
		corner_5, corner_6, corner_7, cube_x, cube_y, cube_z, input ready);
	modport sink (input valid, corner_0, corner_1, corner_2, corner_3, corner_4,
		corner_5, corner_6, corner_7, cube_x, cube_y, cube_z, output ready);
endinterface

interface mct_vert_if;
	logic        valid;
	logic        ready;
	logic [15:0] vert_x;
	logic [15:0] vert_y;
	logic [15:0] vert_z;
	logic [3:0]  edge_number;
	logic        triangle_end;
	logic        cube_done;

	modport source (output valid, vert_x, vert_y, vert_z, edge_number, triangle_end,
		cube_done, input ready);
	modport sink (input valid, vert_x, vert_y, vert_z, edge_number, triangle_end,
		cube_done, output ready);
endinterface
`default_nettype wire

### design/mct_fifo.sv
`default_nettype none
module mct_fifo import mct_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  cube_rec_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output cube_rec_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	cube_rec_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (cnt_q != FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : PW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : PW'(rd_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL)
		else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == FULL && !do_pop) |=> cnt_q == FULL)
		else $error("queue full count lost");
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 && !do_push) |=> cnt_q == '0)
		else $error("queue grew without push");

endmodule
`default_nettype wire

### design/mct_front.sv
`default_nettype none
module mct_front import mct_pkg::*; #(
	parameter int GRID_DIM = GRID_DIM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [15:0] iso,
	mct_cube_if.sink   cube,
	output logic       push_valid,
	input  logic       push_ready,
	output cube_rec_t  push_data
);

	localparam logic [8:0] LIM = 9'(GRID_DIM - 2);

	logic [7:0][15:0] corner;
	logic [7:0]       idx;
	logic [59:0]      row;
	logic [2:0]       ntri;
	logic             in_range;
	logic             keep;
	logic             valid_s1;
	cube_rec_t        rec_s1;

	// case index and table lookup
	always_comb begin
		corner = {cube.corner_7, cube.corner_6, cube.corner_5, cube.corner_4,
			cube.corner_3, cube.corner_2, cube.corner_1, cube.corner_0};
		for (int m = 0; m < 8; m++) begin
			idx[m] = (corner[m] > iso);
		end
		row      = TRI_ROWS[idx][63:4];
		ntri     = tri_count(row);
		in_range = ({1'b0, cube.cube_x} <= LIM) && ({1'b0, cube.cube_y} <= LIM) &&
			({1'b0, cube.cube_z} <= LIM);
		keep     = in_range && (ntri != 3'd0);
	end

	assign cube.ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = rec_s1;

	// classified beat held until the queue takes it; empty cubes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cube.valid && cube.ready) begin
			valid_s1 <= keep;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cube.valid && cube.ready) begin
			rec_s1.corner <= corner;
			rec_s1.x      <= cube.cube_x;
			rec_s1.y      <= cube.cube_y;
			rec_s1.z      <= cube.cube_z;
			rec_s1.row    <= row;
			rec_s1.ntri   <= ntri;
		end
	end

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> push_data.ntri != 3'd0)
		else $error("empty cube queued");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> push_valid && $stable(push_data))
		else $error("queued beat lost");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |-> !cube.ready)
		else $error("front accepted while blocked");

endmodule
`default_nettype wire

### design/mct_back.sv
`default_nettype none
module mct_back import mct_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] iso,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  cube_rec_t   pop_data,
	mct_vert_if.source  vert
);

	localparam int F = FRAC_BITS;
	localparam logic [F:0] F_ONE = {1'b1, {F{1'b0}}};
	localparam logic [3:0] LAST_STEP = 4'(F);

	typedef enum logic [2:0] {ST_IDLE, ST_SETUP, ST_DIV, ST_FIN, ST_OUT} state_t;

	state_t      state_q;
	cube_rec_t   rec_q;
	logic [3:0]  k_q;
	logic [3:0]  len_q;
	logic [1:0]  ph_q;
	logic [3:0]  edge_q;
	logic [2:0]  ca_q;
	logic [2:0]  cb_q;
	logic [16:0] rem_q;
	logic [16:0] dv_q;
	logic [F:0]  low_q;
	logic [F:0]  quo_q;
	logic [3:0]  cnt_q;
	logic        out_valid_q;
	logic [15:0] vx_q;
	logic [15:0] vy_q;
	logic [15:0] vz_q;
	logic [3:0]  en_q;
	logic        te_q;
	logic        cd_q;

	logic [59:0] shifted;
	logic [3:0]  dig;
	logic [3:0]  e;
	logic [2:0]  ca;
	logic [2:0]  cb;
	logic [15:0] c1;
	logic [15:0] c2;
	logic        special;
	logic [F:0]  spec_f;
	logic [15:0] num;
	logic [15:0] den;
	logic [17:0] rem2;
	logic        ge;
	logic [F:0]  fcl;
	logic [8:0]  step;

	function automatic logic [15:0] axis_pos(input logic [7:0] base, input logic d1,
		input logic d2, input logic [8:0] stp);
		logic [15:0] p;
		p = {8'(base + {7'd0, d1}), 8'h00};
		if (d2 && !d1) begin
			p = 16'(p + {7'd0, stp});
		end else if (d1 && !d2) begin
			p = 16'(p - {7'd0, stp});
		end
		return p;
	endfunction

	// edge select and interpolation setup
	always_comb begin
		shifted = rec_q.row << {k_q, 2'b00};
		dig     = shifted[59:56];
		e       = (dig > 4'd11) ? 4'd0 : dig;
		ca      = edge_from(e);
		cb      = edge_to(e);
		c1      = rec_q.corner[ca];
		c2      = rec_q.corner[cb];
		special = 1'b1;
		spec_f  = '0;
		if (iso == c1) begin
			spec_f = '0;
		end else if (iso == c2) begin
			spec_f = F_ONE;
		end else if (c1 == c2) begin
			spec_f = '0;
		end else begin
			special = 1'b0;
		end
		if (c2 > c1) begin
			den = 16'(c2 - c1);
			num = (iso > c1) ? 16'(iso - c1) : 16'd0;
		end else begin
			den = 16'(c1 - c2);
			num = (c1 > iso) ? 16'(c1 - iso) : 16'd0;
		end
		if (num > den) begin
			num = den;
		end
	end

	// one quotient bit per cycle
	always_comb begin
		rem2 = {rem_q, low_q[F]};
		ge   = (rem2 >= {1'b0, dv_q});
		fcl  = (quo_q > F_ONE) ? F_ONE : quo_q;
		step = 9'(fcl) << (8 - F);
	end

	assign pop_ready        = (state_q == ST_IDLE);
	assign vert.valid       = out_valid_q;
	assign vert.vert_x      = vx_q;
	assign vert.vert_y      = vy_q;
	assign vert.vert_z      = vz_q;
	assign vert.edge_number = en_q;
	assign vert.triangle_end = te_q;
	assign vert.cube_done   = cd_q;

	// vertex sequencer with divider and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			len_q       <= '0;
			ph_q        <= '0;
			cnt_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						rec_q   <= pop_data;
						k_q     <= '0;
						ph_q    <= '0;
						len_q   <= 4'(4'(pop_data.ntri) * 4'd3);
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					edge_q <= e;
					ca_q   <= ca;
					cb_q   <= cb;
					if (special) begin
						quo_q   <= spec_f;
						state_q <= ST_FIN;
					end else begin
						rem_q   <= 17'(num) + 17'(den >> (F + 1));
						dv_q    <= {den, 1'b0};
						low_q   <= den[F:0];
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= ge ? 17'(rem2 - {1'b0, dv_q}) : rem2[16:0];
					quo_q <= {quo_q[F-1:0], ge};
					low_q <= low_q << 1;
					cnt_q <= 4'(cnt_q + 1'b1);
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					vx_q <= axis_pos(rec_q.x, CORNER_DX[ca_q], CORNER_DX[cb_q], step);
					vy_q <= axis_pos(rec_q.y, CORNER_DY[ca_q], CORNER_DY[cb_q], step);
					vz_q <= axis_pos(rec_q.z, CORNER_DZ[ca_q], CORNER_DZ[cb_q], step);
					en_q <= edge_q;
					te_q <= (ph_q == 2'd2);
					cd_q <= (4'(k_q + 1'b1) == len_q);
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (vert.ready) begin
						out_valid_q <= 1'b0;
						if (cd_q) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= 4'(k_q + 1'b1);
							ph_q    <= (ph_q == 2'd2) ? 2'd0 : 2'(ph_q + 1'b1);
							state_q <= ST_SETUP;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		vert.valid |-> vert.edge_number <= 4'd11)
		else $error("edge number out of range");
	a_done_ends_tri: assert property (@(posedge clk) disable iff (!arst_n)
		(vert.valid && vert.cube_done) |-> vert.triangle_end)
		else $error("cube ended inside a triangle");
	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !vert.valid)
		else $error("output beat during division");
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		vert.valid |-> state_q == ST_OUT)
		else $error("output valid outside output state");

endmodule
`default_nettype wire

### design/marching_cubes_cell_triangulator_top.sv
// Marching-cubes cell triangulator.
// cube channel: one beat per grid cube, eight 16-bit corner values and the
//   cube's integer grid coordinates. Accepted when valid and ready are high.
// vert channel: one beat per triangle vertex, in triangle-table order, with
//   its edge number, a triangle_end mark and a cube_done mark on the last
//   vertex of the cube. Empty, full and out-of-grid cubes give no beat.
// APB port: register 0 (byte address 0) is iso_level, reset 0x8000. Write it
//   only while no cube is in flight.
// The front classifies a cube combinationally, registers it and queues it (two
//   entries); the back walks its vertices one at a time and takes the next cube
//   only once the last vertex of the current one is taken. Each vertex passes a
//   setup state, a bit-serial divide (skipped when the iso level hits a corner or
//   both corners are equal), a state that forms the position and one that
//   presents it; throughput is set by the single bit-serial divider.
// A stalled vert receiver holds the output register; the queue then fills and
//   cube.ready drops. Reset empties the queue and drops any cube in flight.
`default_nettype none
module marching_cubes_cell_triangulator_top import mct_pkg::*; #(
	parameter int GRID_DIM  = GRID_DIM_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mct_cube_if.sink    cube,
	mct_vert_if.source  vert,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] iso_q;
	logic        push_valid;
	logic        push_ready;
	cube_rec_t   push_data;
	logic        pop_valid;
	logic        pop_ready;
	cube_rec_t   pop_data;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ISO_LEVEL) ? {16'd0, iso_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q <= ISO_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ISO_LEVEL)) begin
			iso_q <= pwdata[15:0];
		end
	end

	mct_front #(.GRID_DIM(GRID_DIM)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.iso        (iso_q),
		.cube       (cube),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mct_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mct_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.iso       (iso_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.vert      (vert)
	);

endmodule
`default_nettype wire

### tb/testbench.sv
module testbench;
	import mct_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mct_cube_if cube_ch ();
	mct_vert_if vert_ch ();

	marching_cubes_cell_triangulator_top dut (
		.clk(clk), .arst_n(arst_n), .cube(cube_ch.sink), .vert(vert_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	typedef struct {
		logic [15:0] vx;
		logic [15:0] vy;
		logic [15:0] vz;
		logic [3:0]  edge_no;
		logic        tri_end;
		logic        done;
	} vertex_t;

	typedef struct {
		logic [15:0] c [8];
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  z;
	} cube_t;

	// edge endpoints, standard numbering
	const int edge_start [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
	const int edge_stop  [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};
	const int off_x [8] = '{0, 1, 1, 0, 0, 1, 1, 0};
	const int off_y [8] = '{0, 0, 0, 0, 1, 1, 1, 1};
	const int off_z [8] = '{0, 0, 1, 1, 0, 0, 1, 1};

	// triangle table rows, edge digits as text
	const string tri_text [256] = '{
"","083","019","183981","12a","08312a","92a029","2832a8a98",
"3b2","0b28b0","19023b","1b219b98b","3a1ba3","0a108a8ba","3903b9ba9","98aa8b",
"478","430734","019847","419471731","12a847","34730412a","92a902847","2a9297273794",
"8473b2","b47b24204","90184723b","47b94b9b2921","3a13ba784","1ba14b1047b4","47890b9bab03","47b4b99ba",
"954","954083","054150","854835315","12a954","30812a495","52a542402","2a5325354348",
"95423b","0b208b495","05401523b","21525828b485","a3ba13954","4950818a18ba","54050b5bab03","54858aa8b",
"978579","930953573","078017157","153357","978957a12","a12950530573","802825857a52","2a5253357",
"7957893b2","95797292027b","23b018178157","b21b17715","958857a13a3b","5705097b010aba0","ba0b03a50807570","ba57b5",
"a65","0835a6","9015a6","1831985a6","165261","165126308","965906026","598582526328",
"23ba65","b08b20a65","01923b5a6","5a61929b298b","63b653513","08b0b50515b6","3b6036065059","65969bb98",
"5a6478","43047365a","1905a6847","a65197173794","612651478","125526304347","847905065026","739794329596269",
"3b2784a65","5a647242027b","01947823b5a6","9219b294b7b45a6","8473b53515b6","51b5b610b7b404b","059065036b63847","65969b4797b9",
"a4964a","4a649a083","a01a60640","83181686461a","149124264","308129249264","024426","832824426",
"a49a64b23","08228b49a4a6","3b201606461a","64161a48121b8b1","964936913b63","8b1810b61914641","3b6360064","648b68",
"7a678a89a","0730a709a67a","a671a7178180","a67a71173","126168189867","269291679093739","780706602","732672",
"23ba68a89867","20727b09767a9a7","1801781a767a23b","b21b17a61671","896867916b63136","091b67","7807063b0b60","7b6",
"76b","308b76","019b76","819831b76","a126b7","12a3086b7","2902a96b7","6b72a3a83a98",
"723627","708760620","276237019","162186198876","a76a17137","a7617a187108","03707a0a96a7","76a7a88a9",
"684b86","36b306046","86b846901","946963931b36","6846b82a1","12a30b06b046","4b846b0292a9","a93a32943b36463",
"823842462","042462","190234246438","194142246","8138618466a1","a10a06604","4634386a3039a93","a946a4",
"49576b","083495b76","50154076b","b76834354315","954a1276b","6b712a083495","76b54a42a402","348354325a52b76",
"723762549","954086062687","362376150540","628687218485158","954a16176137","16a176107870954","40a4a503a6a737a","76a7a854a48a",
"6956b9b89","36b063056095","0b805b01556b","6b3635531","12a95b9b8b56","0b306b09656912a","b85b56805a52025","6b36352a3a53",
"589528562382","956960062","158180568382628","156216","13616a386569896","a10a06950560","03856a","a56",
"b5a75b","b5ab75830","5b75ab190","a75ab7981831","b12b71751","08312717572b","9759279022b7","75272b592328982",
"25a235375","820852875a25","9015a35373a2","982921872a25752","135375","087071175","903935537","987597",
"5845a8ab8","5045b05abb30","01984a8aba45","ab4a45b34941314","2512852b8458","04b0b345b2b151b","0250592b5458b85","9452b3",
"25a352345384","5a2524420","3a235a385458019","5a2524192942","845853351","045105","845853905035","945",
"4b749b9ab","0834979b79ab","1ab1b414074b","3143481a474bab4","4b79b492b912","9749b791b2b1083","b74b42240","b74b42834324",
"29a279237749","9a7974a27870207","37a3a274a1a040a","1a2874","491417713","491417081871","403743","487",
"9a8ab8","30939bb9a","01a0a88ab","31ab3a","12b1b99b8","30939b1292b9","02b80b","32b",
"23828aa89","9a2092","23828a0181a8","1a2","138918","091","038",""
	};

	logic [15:0] iso_shadow;
	vertex_t     expected_verts [$];
	int          mismatches;
	bit          stim_done;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	initial begin
		#40000000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int hex_val(byte ch);
		if (ch >= "0" && ch <= "9") return ch - "0";
		return ch - "a" + 10;
	endfunction

	// interpolation fraction along an edge, 0..256
	function automatic int edge_frac(int c1, int c2, int iso);
		int num;
		int den;
		int f;
		if (iso == c1) return 0;
		if (iso == c2) return 256;
		if (c1 == c2) return 0;
		if (c2 > c1) begin
			den = c2 - c1;
			num = (iso > c1) ? iso - c1 : 0;
		end else begin
			den = c1 - c2;
			num = (c1 > iso) ? c1 - iso : 0;
		end
		if (num > den) num = den;
		f = ((num << 9) + den) / (2 * den);
		if (f > 256) f = 256;
		return f;
	endfunction

	function automatic logic [15:0] axis_coord(int base, int d1, int d2, int step);
		int p;
		p = (base + d1) << 8;
		if (d2 > d1) p = p + step;
		else if (d2 < d1) p = p - step;
		return p[15:0];
	endfunction

	// queue the vertices this cube produces
	function automatic void triangulate(cube_t cb);
		int      idx;
		int      len;
		int      e;
		int      a;
		int      b;
		int      st;
		vertex_t v;
		idx = 0;
		if (cb.x > 254 || cb.y > 254 || cb.z > 254) return;
		for (int m = 0; m < 8; m++)
			if (cb.c[m] > iso_shadow) idx |= 1 << m;
		len = tri_text[idx].len();
		if (len > 15) len = 15;
		len -= len % 3;
		for (int k = 0; k < len; k++) begin
			e = hex_val(tri_text[idx][k]);
			a = edge_start[e];
			b = edge_stop[e];
			st = edge_frac(cb.c[a], cb.c[b], iso_shadow);
			v.vx = axis_coord(cb.x, off_x[a], off_x[b], st);
			v.vy = axis_coord(cb.y, off_y[a], off_y[b], st);
			v.vz = axis_coord(cb.z, off_z[a], off_z[b], st);
			v.edge_no = e[3:0];
			v.tri_end = (k % 3 == 2);
			v.done = (k + 1 == len);
			expected_verts.insert(expected_verts.size(), v);
		end
	endfunction

	// idle pattern: bursts with no gaps, otherwise ~36% idle
	bit no_gaps;
	always @(posedge clk) no_gaps <= ($urandom_range(0, 99) < 3) ? ~no_gaps : no_gaps;

	function automatic bit take_gap();
		return !no_gaps && ($urandom_range(0, 99) < 36);
	endfunction

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_ch.ready <= 1'b0;
		end else begin
			vert_ch.ready <= !take_gap();
		end
	end

	always @(posedge clk) begin
		vertex_t w;
		if (arst_n && vert_ch.valid && vert_ch.ready) begin
			if (expected_verts.size() == 0) begin
				$error("vertex beat with nothing expected");
				mismatches++;
			end else begin
				w = expected_verts.pop_front();
				if (vert_ch.vert_x !== w.vx) begin
					$error("vert_x expected %0h actual %0h", w.vx, vert_ch.vert_x);
					mismatches++;
				end
				if (vert_ch.vert_y !== w.vy) begin
					$error("vert_y expected %0h actual %0h", w.vy, vert_ch.vert_y);
					mismatches++;
				end
				if (vert_ch.vert_z !== w.vz) begin
					$error("vert_z expected %0h actual %0h", w.vz, vert_ch.vert_z);
					mismatches++;
				end
				if (vert_ch.edge_number !== w.edge_no) begin
					$error("edge_number expected %0d actual %0d", w.edge_no,
						vert_ch.edge_number);
					mismatches++;
				end
				if (vert_ch.triangle_end !== w.tri_end) begin
					$error("triangle_end expected %0b actual %0b", w.tri_end,
						vert_ch.triangle_end);
					mismatches++;
				end
				if (vert_ch.cube_done !== w.done) begin
					$error("cube_done expected %0b actual %0b", w.done, vert_ch.cube_done);
					mismatches++;
				end
			end
		end
	end

	task automatic write_iso(logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= {16'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		iso_shadow = val;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		cube_ch.valid <= 1'b0;
		while (expected_verts.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		// a cube with no vertices may still be in flight
		repeat (250) @(posedge clk);
	endtask

	// drive one cube and wait for acceptance; valid stays up for a following beat
	task automatic send_cube(cube_t cb);
		while (take_gap()) begin
			cube_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cube_ch.valid <= 1'b1;
		cube_ch.corner_0 <= cb.c[0];
		cube_ch.corner_1 <= cb.c[1];
		cube_ch.corner_2 <= cb.c[2];
		cube_ch.corner_3 <= cb.c[3];
		cube_ch.corner_4 <= cb.c[4];
		cube_ch.corner_5 <= cb.c[5];
		cube_ch.corner_6 <= cb.c[6];
		cube_ch.corner_7 <= cb.c[7];
		cube_ch.cube_x <= cb.x;
		cube_ch.cube_y <= cb.y;
		cube_ch.cube_z <= cb.z;
		do @(posedge clk); while (!(cube_ch.valid && cube_ch.ready));
		triangulate(cb);
	endtask

	function automatic cube_t make_cube(int kind);
		cube_t cb;
		int    sel;
		for (int m = 0; m < 8; m++) begin
			case (kind)
				0: cb.c[m] = 16'($urandom());
				1: cb.c[m] = 16'(int'(iso_shadow) + $urandom_range(0, 6) - 3);
				default: begin
					sel = $urandom_range(0, 3);
					cb.c[m] = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hffff :
						(sel == 2) ? iso_shadow : 16'($urandom());
				end
			endcase
		end
		sel = $urandom_range(0, 19);
		cb.x = (sel == 0) ? 8'($urandom_range(254, 255)) : 8'($urandom());
		cb.y = (sel == 1) ? 8'hff : 8'($urandom());
		cb.z = (sel == 2) ? 8'hff : 8'($urandom());
		if (sel > 4) begin
			if (cb.x == 8'hff) cb.x = 8'hfe;
			if (cb.y == 8'hff) cb.y = 8'hfe;
			if (cb.z == 8'hff) cb.z = 8'hfe;
		end
		return cb;
	endfunction

	// directed table: corner bitmap (1 = 0xffff, 0 = 0 unless eq_iso is set), coords
	typedef struct {
		logic [7:0]  above;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  z;
		bit          eq_iso;
	} dir_row_t;

	const dir_row_t dir_table [18] = '{
		'{8'h00, 8'd0,   8'd0,   8'd0,   1'b0},   // empty cube
		'{8'hff, 8'd3,   8'd4,   8'd5,   1'b0},   // full cube
		'{8'h01, 8'd0,   8'd0,   8'd0,   1'b0},
		'{8'h80, 8'd254, 8'd254, 8'd254, 1'b0},   // highest cube in grid
		'{8'h01, 8'd255, 8'd0,   8'd0,   1'b0},   // outside the grid on x
		'{8'h01, 8'd0,   8'd255, 8'd0,   1'b0},
		'{8'h01, 8'd0,   8'd0,   8'd255, 1'b0},
		'{8'h7e, 8'd10,  8'd20,  8'd30,  1'b0},
		'{8'h69, 8'd1,   8'd2,   8'd3,   1'b0},   // four triangles
		'{8'h96, 8'd200, 8'd100, 8'd50,  1'b0},
		'{8'h3c, 8'd7,   8'd7,   8'd7,   1'b0},
		'{8'ha5, 8'd170, 8'd85,  8'd170, 1'b0},
		'{8'h5a, 8'd85,  8'd170, 8'd85,  1'b0},
		'{8'h01, 8'd9,   8'd9,   8'd9,   1'b1},   // corners other than corner 0 sit on the iso level
		'{8'hfe, 8'd9,   8'd9,   8'd9,   1'b1},   // corner 0 sits on the iso level
		'{8'h0f, 8'd128, 8'd64,  8'd32,  1'b0},
		'{8'hf0, 8'd16,  8'd8,   8'd4,   1'b0},
		'{8'h33, 8'd2,   8'd4,   8'd8,   1'b0}
	};

	initial begin
		cube_t       cb;
		logic [15:0] iso_list [6];
		int          n;
		iso_list = '{16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'hfffe, 16'h1234};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'd0;
		cube_ch.valid = 1'b0;
		cube_ch.corner_0 = '0;
		cube_ch.corner_1 = '0;
		cube_ch.corner_2 = '0;
		cube_ch.corner_3 = '0;
		cube_ch.corner_4 = '0;
		cube_ch.corner_5 = '0;
		cube_ch.corner_6 = '0;
		cube_ch.corner_7 = '0;
		cube_ch.cube_x = '0;
		cube_ch.cube_y = '0;
		cube_ch.cube_z = '0;
		mismatches = 0;
		stim_done = 0;
		iso_shadow = ISO_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part at reset iso level
		foreach (dir_table[i]) begin
			for (int m = 0; m < 8; m++)
				cb.c[m] = dir_table[i].above[m] ? 16'hffff :
					(dir_table[i].eq_iso ? iso_shadow : 16'h0000);
			if (dir_table[i].eq_iso) begin
				for (int m = 0; m < 8; m++)
					cb.c[m] = dir_table[i].above[m] ? (m == 0 ? 16'hffff : 16'h9000) :
						iso_shadow;
			end
			cb.x = dir_table[i].x;
			cb.y = dir_table[i].y;
			cb.z = dir_table[i].z;
			send_cube(cb);
		end
		// one triangle around corner 0, cut points near mid-edge
		cb.c = '{16'hffff, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000};
		cb.x = 8'd1;
		cb.y = 8'd1;
		cb.z = 8'd1;
		send_cube(cb);
		drain();

		// random phases across iso settings
		n = 0;
		foreach (iso_list[p]) begin
			write_iso(iso_list[p]);
			repeat (25) begin
				send_cube(make_cube(n % 3));
				n++;
			end
			drain();
		end
		stim_done = 1;

		if (expected_verts.size() != 0) begin
			$error("%0d vertices never arrived", expected_verts.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### marching_cubes_cell_triangulator_top.f
design/mct_pkg.sv
design/mct_if.sv
design/mct_fifo.sv
design/mct_front.sv
design/mct_back.sv
design/marching_cubes_cell_triangulator_top.sv
tb/testbench.sv
